/* rtl/lota_pkg.sv */
// Shared types and constants for the LoRa time-on-air unit.
// Holds the field widths, register indexes, divider cell payload and the
// reciprocal used for the final millisecond conversion. No dependencies.
`default_nettype none

package lota_pkg;

  // Field and register widths.
  localparam int LEN_W     = 8;
  localparam int OUT_W     = 22;
  localparam int SF_W      = 4;
  localparam int BW_W      = 2;
  localparam int CR_W      = 4;
  localparam int PRE_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [SF_W-1:0]  SF_RESET  = 4'd11;
  localparam logic [BW_W-1:0]  BW_RESET  = 2'd1;
  localparam logic [CR_W-1:0]  CR_RESET  = 4'd5;
  localparam logic [PRE_W-1:0] PRE_RESET = 16'd16;

  // Legal ranges used for clamping.
  localparam logic [SF_W-1:0] SF_MIN  = 4'd5;
  localparam logic [SF_W-1:0] SF_MAX  = 4'd12;
  localparam logic [BW_W-1:0] BW_MAX  = 2'd2;
  localparam logic [CR_W-1:0] CR_MIN  = 4'd5;
  localparam logic [CR_W-1:0] CR_MAX  = 4'd8;

  // Symbol time exponent: Ts = 2^(SF + 3 - bw). Low data rate above 16 ms.
  localparam int EXP_W = 4;
  localparam logic [EXP_W-1:0] EXP_LDRO = 4'd14;

  // Divider: dividend up to 520, divisor 5..12, one quotient bit per cell.
  localparam int DIV_W  = 10;
  localparam int REM_W  = 5;
  localparam int KDIV_W = 4;
  localparam int Q_W    = 7;
  localparam int NCELL  = DIV_W;

  // Symbol sum, shifted value and reciprocal of 125 for the ms conversion.
  localparam int SUM_W       = 19;
  localparam int VAL_W       = 29;
  localparam int RECIP_W     = 30;
  localparam int PROD_W      = VAL_W + RECIP_W;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 30'd549755814;

  // Partial remainder and shifting dividend/quotient word of one cell.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] dq;
  } lota_cell_t;

endpackage

`default_nettype wire

/* rtl/lota_if.sv */
// Valid/ready channel interfaces for the LoRa time-on-air unit.
// Depends on lota_pkg for the payload widths.
`default_nettype none

interface lota_in_if import lota_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] payload_length;

  modport source (output valid, output payload_length, input ready);
  modport sink   (input valid, input payload_length, output ready);
endinterface

interface lota_out_if import lota_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] airtime_ms;

  modport source (output valid, output airtime_ms, input ready);
  modport sink   (input valid, input airtime_ms, output ready);
endinterface

`default_nettype wire

/* rtl/lota_div_cell.sv */
// One restoring division step with its own pipeline register.
// Depends on lota_pkg for the cell payload type.
`default_nettype none

module lota_div_cell import lota_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [KDIV_W-1:0] divisor,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire lota_cell_t        up_data,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output lota_cell_t             dn_data
);

  logic       valid_r;
  lota_cell_t data_r;
  lota_cell_t data_nxt;
  logic [REM_W-1:0] shifted;

  // Shift the next dividend bit into the remainder and try a subtraction.
  assign shifted = {up_data.rem[REM_W-2:0], up_data.dq[DIV_W-1]};

  always_comb begin
    data_nxt.dq  = {up_data.dq[DIV_W-2:0], 1'b0};
    data_nxt.rem = shifted;
    if (shifted >= {1'b0, divisor}) begin
      data_nxt.rem   = shifted - {1'b0, divisor};
      data_nxt.dq[0] = 1'b1;
    end
  end

  // The stage loads when it is empty or its content moves on.
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

/* rtl/lota_scale.sv */
// Tail of the pipeline: symbol count, microsecond sum and ms conversion.
// Two register stages; the second one is the output register.
// Depends on lota_pkg.
`default_nettype none

module lota_scale import lota_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CR_W-1:0]   coding_rate,
  input  wire logic [PRE_W-1:0]  preamble,
  input  wire logic [EXP_W-1:0]  val_shift,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire logic [DIV_W-1:0]  blocks,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output logic [OUT_W-1:0]       airtime_ms
);

  logic               val_valid_r;
  logic [VAL_W-1:0]   val_r;
  logic [VAL_W-1:0]   val_nxt;
  logic               prod_valid_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;
  logic               prod_load;
  logic [10:0]        blk_cr;
  logic [9:0]         payload_syms;
  logic [SUM_W-1:0]   sym_sum;

  // Payload symbols 8 + blocks * CR, then 4 * (preamble + payload) + 17 in
  // quarter symbols. Scaling by Ts / 32 leaves a division by 125 for ms.
  assign blk_cr       = {{(11-Q_W){1'b0}}, blocks[Q_W-1:0]} * {{(11-CR_W){1'b0}}, coding_rate};
  assign payload_syms = 10'(blk_cr + 11'd8);
  assign sym_sum      = {1'b0, preamble, 2'b00} + {7'd0, payload_syms, 2'b00} + 19'd17;
  assign val_nxt      = {{(VAL_W-SUM_W){1'b0}}, sym_sum} << val_shift;

  // Division by 125 through a multiply by its scaled reciprocal.
  assign prod_nxt = val_r * RECIP_MUL;

  // Handshake between the two stages.
  assign prod_load = !prod_valid_r || dn_ready;
  assign up_ready  = !val_valid_r || prod_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_valid_r  <= 1'b0;
      prod_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        val_valid_r <= up_valid;
      end
      if (prod_load) begin
        prod_valid_r <= val_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      val_r <= val_nxt;
    end
    if (prod_load && val_valid_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign dn_valid   = prod_valid_r;
  assign airtime_ms = prod_r[RECIP_SHIFT+OUT_W-1:RECIP_SHIFT];

endmodule

`default_nettype wire

/* rtl/lora_time_on_air_unit.sv */
// LoRa time-on-air unit: payload length in bytes to on-air time in ms.
//
// Usage: the input channel carries payload_length, the output channel
// airtime_ms; both move one transfer per cycle when valid and ready are
// high. Spreading factor, bandwidth code, coding rate denominator and
// preamble length are written through cfg_we/cfg_index/cfg_data while no
// item is in flight. The header is explicit and the CRC is on.
// An input transfer passes through ten division cells, one for each bit of
// the ceiling dividend, then a summing stage and the reciprocal multiply
// that feeds the output register. One item enters per cycle unless a
// receiver stall has filled the pipeline; every stage holds its own valid bit.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling empty slots, so input stays ready until
// every stage is full. Synchronous reset empties the pipeline and loads
// SF11, 250 kHz, coding rate 4/5 and a 16-symbol preamble.
// Depends on lota_pkg, lota_if, lota_div_cell and lota_scale.
`default_nettype none

module lora_time_on_air_unit import lota_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  lota_in_if.sink                   in_ch,
  lota_out_if.source                out_ch
);

  logic [SF_W-1:0]  sf_r;
  logic [BW_W-1:0]  bw_r;
  logic [CR_W-1:0]  cr_r;
  logic [PRE_W-1:0] pre_r;

  logic [SF_W-1:0]   sf_c;
  logic [BW_W-1:0]   bw_c;
  logic [CR_W-1:0]   cr_c;
  logic [EXP_W-1:0]  ts_exp;
  logic              ldro;
  logic [KDIV_W-1:0] divisor;
  logic [EXP_W-1:0]  val_shift;
  logic [DIV_W-1:0]  len_term;
  logic [DIV_W-1:0]  num_pos;
  logic [DIV_W-1:0]  dividend;

  logic       chain_valid [0:NCELL];
  logic       chain_ready [0:NCELL];
  lota_cell_t chain_data  [0:NCELL];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r  <= SF_RESET;
      bw_r  <= BW_RESET;
      cr_r  <= CR_RESET;
      pre_r <= PRE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SF:  sf_r  <= cfg_data[SF_W-1:0];
        CFG_BW:  bw_r  <= cfg_data[BW_W-1:0];
        CFG_CR:  cr_r  <= cfg_data[CR_W-1:0];
        CFG_PRE: pre_r <= cfg_data[PRE_W-1:0];
      endcase
    end
  end

  // Clamp the settings to their legal ranges.
  assign sf_c = (sf_r < SF_MIN) ? SF_MIN : ((sf_r > SF_MAX) ? SF_MAX : sf_r);
  assign bw_c = (bw_r > BW_MAX) ? BW_MAX : bw_r;
  assign cr_c = (cr_r < CR_MIN) ? CR_MIN : ((cr_r > CR_MAX) ? CR_MAX : cr_r);

  // Symbol time is 2^ts_exp us; low data rate optimization above 16 ms.
  assign ts_exp    = sf_c + 4'd3 - {2'b00, bw_c};
  assign ldro      = (ts_exp >= EXP_LDRO);
  assign divisor   = sf_c - {2'b00, ldro, 1'b0};
  assign val_shift = ts_exp - 4'd5;

  // The payload numerator is a multiple of four: 4 * (2L - SF + 11).
  // Negative or zero numerators give no extra blocks. Adding divisor - 1
  // turns the truncating division into a ceiling.
  assign len_term = {1'b0, in_ch.payload_length, 1'b0} + 10'd11;
  assign num_pos  = (len_term > {6'd0, sf_c}) ? (len_term - {6'd0, sf_c}) : '0;
  assign dividend = num_pos + {6'd0, divisor} - 10'd1;

  assign chain_valid[0]     = in_ch.valid;
  assign chain_data[0].rem  = '0;
  assign chain_data[0].dq   = dividend;
  assign in_ch.ready        = chain_ready[0];

  // Row of restoring division cells, one quotient bit each.
  for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
    lota_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .divisor  (divisor),
      .up_valid (chain_valid[gi]),
      .up_ready (chain_ready[gi]),
      .up_data  (chain_data[gi]),
      .dn_valid (chain_valid[gi+1]),
      .dn_ready (chain_ready[gi+1]),
      .dn_data  (chain_data[gi+1])
    );
  end

  // Symbol count, microsecond total and ms conversion.
  lota_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .coding_rate (cr_c),
    .preamble    (pre_r),
    .val_shift   (val_shift),
    .up_valid    (chain_valid[NCELL]),
    .up_ready    (chain_ready[NCELL]),
    .blocks      (chain_data[NCELL].dq),
    .dn_valid    (out_ch.valid),
    .dn_ready    (out_ch.ready),
    .airtime_ms  (out_ch.airtime_ms)
  );

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for lora_time_on_air_unit: payload lengths in, airtime out.
// A scoreboard class predicts each airtime from its own copy of the registers.
// Depends on lota_pkg, lota_if and the RTL of the unit.
`default_nettype none

import lota_pkg::*;

// Bandwidth codes as the register takes them; the last one is reserved.
localparam logic [BW_W-1:0] BW_125K     = 2'd0;
localparam logic [BW_W-1:0] BW_250K     = 2'd1;
localparam logic [BW_W-1:0] BW_500K     = 2'd2;
localparam logic [BW_W-1:0] BW_RESERVED = 2'd3;

class airtime_board;
  logic [SF_W-1:0]  sf;
  logic [BW_W-1:0]  bw;
  logic [CR_W-1:0]  cr;
  logic [PRE_W-1:0] pre;
  logic [OUT_W-1:0] airtime_q[$];
  int               errors;

  function new();
    sf     = SF_RESET;
    bw     = BW_RESET;
    cr     = CR_RESET;
    pre    = PRE_RESET;
    errors = 0;
  endfunction

  // Mirror a register write, keeping only the bits the register holds.
  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_SF:  sf  = data[SF_W-1:0];
      CFG_BW:  bw  = data[BW_W-1:0];
      CFG_CR:  cr  = data[CR_W-1:0];
      CFG_PRE: pre = data[PRE_W-1:0];
      default: ;
    endcase
  endfunction

  // Exact airtime in microseconds, truncated to whole milliseconds.
  function logic [OUT_W-1:0] airtime_for(logic [LEN_W-1:0] len);
    longint sf_eff;
    longint cr_eff;
    longint sym_us;
    longint num;
    longint den;
    longint blocks;
    longint syms;
    longint total_us;
    sf_eff = (sf < SF_MIN) ? SF_MIN : ((sf > SF_MAX) ? SF_MAX : sf);
    cr_eff = (cr < CR_MIN) ? CR_MIN : ((cr > CR_MAX) ? CR_MAX : cr);
    sym_us = 1;
    sym_us = sym_us << sf_eff;
    // The reserved bandwidth code behaves as 500 kHz.
    if (bw == BW_125K) begin
      sym_us = sym_us * 8;
    end else if (bw == BW_250K) begin
      sym_us = sym_us * 4;
    end else begin
      sym_us = sym_us * 2;
    end
    // Low data rate optimization narrows the payload bits carried per block.
    num = 8 * longint'(len) - 4 * sf_eff + 44;
    den = 4 * (sf_eff - ((sym_us > 16000) ? 2 : 0));
    blocks = (num > 0) ? (num + den - 1) / den : 0;
    syms = 8 + blocks * cr_eff;
    total_us = ((4 * longint'(pre) + 17) * sym_us) / 4 + syms * sym_us;
    return OUT_W'(total_us / 1000);
  endfunction

  function void note_length(logic [LEN_W-1:0] len);
    airtime_q.push_back(airtime_for(len));
  endfunction

  function void check_airtime(logic [OUT_W-1:0] got);
    logic [OUT_W-1:0] want;
    if (airtime_q.size() == 0) begin
      $error("airtime_ms: expected no result, actual %0d", got);
      errors++;
    end else begin
      want = airtime_q.pop_front();
      if (got !== want) begin
        $error("airtime_ms: expected %0d, actual %0d", want, got);
        errors++;
      end
    end
  endfunction

  function int pending();
    return airtime_q.size();
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 16;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 130;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_e;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   cycles = 0;
  airtime_board         board;

  lota_in_if  in_ch ();
  lota_out_if out_ch ();

  lora_time_on_air_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Clock with a 10-unit period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_airtime(out_ch.airtime_ms);
    end
  end

  // Receiver: switches between no stalls, random stalls and long stalls.
  initial begin
    stall_mode_e mode;
    int          span;
    int          hold;
    out_ch.ready = 1'b0;
    mode = STALL_NONE;
    span = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = stall_mode_e'($urandom_range(0, 2));
        span = $urandom_range(50, 300);
      end
      span--;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          STALL_NONE: out_ch.ready <= 1'b1;
          STALL_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 15) == 0) begin
              hold = $urandom_range(1, 30);
              out_ch.ready <= 1'b0;
            end else begin
              out_ch.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Offer one length and hold it until the transfer happens.
  task automatic send_length(logic [LEN_W-1:0] len);
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.payload_length <= len;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    board.note_length(len);
  endtask

  // Sender gap; the payload carries junk while valid is low.
  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid          <= 1'b0;
      in_ch.payload_length <= LEN_W'($urandom);
    end
  endtask

  // Stop sending and wait until every predicted airtime has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Registers change only with the pipeline empty.
  task automatic configure(logic [CFG_W-1:0] sf_data, logic [CFG_W-1:0] bw_data,
                           logic [CFG_W-1:0] cr_data, logic [CFG_W-1:0] pre_data);
    wait_drained();
    write_reg(CFG_SF, sf_data);
    write_reg(CFG_BW, bw_data);
    write_reg(CFG_CR, cr_data);
    write_reg(CFG_PRE, pre_data);
  endtask

  initial begin
    int               phase;
    int               item;
    int               burst;
    bit               no_gaps;
    logic [LEN_W-1:0] len;
    logic [CFG_W-1:0] sf_data;
    logic [CFG_W-1:0] bw_data;
    logic [CFG_W-1:0] cr_data;
    logic [CFG_W-1:0] pre_data;

    board                = new();
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_SF;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.payload_length = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings, with both length extremes and alternating bits.
    send_length(8'd0);
    send_length(8'd255);
    send_length(8'd1);
    send_length(8'haa);
    send_length(8'h55);

    // Slowest setting: largest result; an empty payload has a negative numerator.
    configure(16'd12, CFG_W'(BW_125K), 16'd8, 16'hffff);
    send_length(8'd0);
    send_length(8'd255);
    send_length(8'd3);

    // Fastest setting with a zero preamble.
    configure(16'd5, CFG_W'(BW_500K), 16'd5, 16'd0);
    send_length(8'd0);
    send_length(8'd255);

    // Values below range and the reserved bandwidth code.
    configure(16'd4, CFG_W'(BW_RESERVED), 16'd4, 16'd1);
    send_length(8'd0);
    send_length(8'd200);

    // Values above range.
    configure(16'd15, CFG_W'(BW_125K), 16'd15, 16'd8);
    send_length(8'd0);
    send_length(8'd255);

    // Zero SF and CR fields, with high data bits that the registers drop.
    configure(16'hfff0, 16'hfffd, 16'h00f0, 16'd2);
    send_length(8'd10);

    // Random phases, each with its own register setting.
    for (phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 7))
        0: sf_data = CFG_W'(SF_MIN);
        1: sf_data = CFG_W'(SF_MAX);
        2: sf_data = CFG_W'($urandom);
        default: sf_data = CFG_W'($urandom_range(5, 12));
      endcase
      bw_data = CFG_W'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
        bw_data[CFG_W-1:BW_W] = (CFG_W-BW_W)'($urandom);
      end
      case ($urandom_range(0, 7))
        0: cr_data = CFG_W'(CR_MIN);
        1: cr_data = CFG_W'(CR_MAX);
        2: cr_data = CFG_W'($urandom);
        default: cr_data = CFG_W'($urandom_range(5, 8));
      endcase
      case ($urandom_range(0, 7))
        0: pre_data = '0;
        1: pre_data = '1;
        2: pre_data = CFG_W'($urandom);
        default: pre_data = CFG_W'($urandom_range(1, 64));
      endcase
      configure(sf_data, bw_data, cr_data, pre_data);

      no_gaps = (phase % 4 == 1);
      item = 0;
      while (item < PHASE_ITEMS) begin
        burst = $urandom_range(1, 40);
        while (burst > 0 && item < PHASE_ITEMS) begin
          case ($urandom_range(0, 9))
            0: len = '0;
            1: len = '1;
            default: len = LEN_W'($urandom);
          endcase
          send_length(len);
          item++;
          burst--;
          // Now and then hold off until the pipeline has emptied.
          if (item == PHASE_ITEMS / 2 && phase % 3 == 0) begin
            wait_drained();
          end
        end
        if (!no_gaps) begin
          idle_sender($urandom_range(0, 15));
        end
      end
    end

    wait_drained();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
